// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define STS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/stsched_pkg.sv
// ----------------------------------------------------------------------------
// stsched_pkg
// Types, codes and helpers of the sorted timer scheduler.
// ----------------------------------------------------------------------------
package stsched_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int IDX_W      = $clog2(NUM_TIMERS);
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
	localparam int ID_W       = 5;
	localparam int TIME_W     = 64;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_STOP   = 2'd1,
		OP_MANAGE = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_NONE    = 2'd2
	} kind_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [ID_W-1:0]     timer_id;
		logic [TIME_W-1:0]   ticks;
		logic                periodic;
		logic [TIME_W-1:0]   now_time;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0] result_timer;
		kind_t           kind;
		logic            is_pending;
		logic            last;
	} out_word_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_REMOVE,
		CELL_POP,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [ID_W-1:0]   key;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] now;
	} cell_cmd_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   tid;
	} cell_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_POP,
		ST_EMIT,
		ST_RQ_RD,
		ST_RQ_INS
	} state_t;

	localparam logic [TIME_W-1:0] SIGN = {1'b1, {(TIME_W-1){1'b0}}};

	function automatic logic earlier(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] now);
		return ((a - now) ^ SIGN) < ((b - now) ^ SIGN);
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] id);
		return IDX_W'(id);
	endfunction

	function automatic logic id_ok(input logic [ID_W-1:0] id);
		return int'(id) < NUM_TIMERS;
	endfunction

endpackage

// File: hw/rtl/stsched_cell.sv
// ----------------------------------------------------------------------------
// stsched_cell
// One slot of the sorted queue: holds, removes, shifts or inserts an entry.
// ----------------------------------------------------------------------------
module stsched_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stsched_pkg::cell_cmd_t  cmd,
	input  stsched_pkg::cell_link_t left,
	input  logic                   left_seen,
	input  logic                   left_go,
	input  stsched_pkg::cell_link_t right,
	output stsched_pkg::cell_link_t own,
	output logic                   seen,
	output logic                   go
);
	import stsched_pkg::*;

	logic              valid_q;
	logic [TIME_W-1:0] deadline_q;
	logic [ID_W-1:0]   tid_q;
	logic              go_here;
	logic              take;
	cell_link_t        nxt;

	assign own     = '{valid: valid_q, deadline: deadline_q, tid: tid_q};
	assign seen    = left_seen | (valid_q && tid_q == cmd.key);
	assign go_here = !valid_q || earlier(cmd.deadline, deadline_q, cmd.now);
	assign go      = left_go | go_here;

	always_comb begin
		nxt  = own;
		take = 1'b0;
		case (cmd.op)
			CELL_REMOVE: begin
				if (seen) begin
					nxt  = right;
					take = 1'b1;
				end
			end
			CELL_POP: begin
				nxt  = right;
				take = 1'b1;
			end
			CELL_INSERT: begin
				if (left_go) begin
					nxt  = left;
					take = 1'b1;
				end else if (go_here) begin
					nxt  = '{valid: 1'b1, deadline: cmd.deadline, tid: cmd.key};
					take = 1'b1;
				end
			end
			default: begin
				nxt = own;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			deadline_q <= nxt.deadline;
			tid_q      <= nxt.tid;
		end
	end

endmodule

// File: hw/rtl/stsched_ctrl.sv
// ----------------------------------------------------------------------------
// stsched_ctrl
// Command sequencer: drives the cell row, holds periods, pending flags and
// the expired-timer stack and queue, and forms the result words.
// ----------------------------------------------------------------------------
module stsched_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  stsched_pkg::in_word_t   cmd,
	output logic                   strobe,
	output stsched_pkg::out_word_t  result,
	output stsched_pkg::cell_cmd_t  ccmd,
	input  stsched_pkg::cell_link_t head
);
	import stsched_pkg::*;

	state_t            state_q, state_d;
	in_word_t          in_q;
	logic [ID_W-1:0]   lifo_q [NUM_TIMERS];
	logic [ID_W-1:0]   fifo_q [NUM_TIMERS];
	logic [TIME_W-1:0] period_mem [NUM_TIMERS];
	logic [TIME_W-1:0] rd_q;
	logic [CNT_W-1:0]  cnt_q, rem_q;
	logic [NUM_TIMERS-1:0] pending_q, nz_q;
	logic              strobe_q, res_vld;
	out_word_t         result_q, res_d;
	logic              due;
	logic [IDX_W-1:0]  in_idx, fifo_idx, lifo_idx;

	assign busy     = state_q != ST_IDLE;
	assign strobe   = strobe_q;
	assign result   = result_q;
	assign in_idx   = to_idx(in_q.timer_id);
	assign fifo_idx = to_idx(fifo_q[0]);
	assign lifo_idx = to_idx(lifo_q[0]);
	assign due      = head.valid && (((in_q.now_time - head.deadline) & SIGN) == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd.opcode == OP_MANAGE) begin
						state_d = ST_POP;
					end else if ((cmd.opcode == OP_START || cmd.opcode == OP_STOP)
							&& id_ok(cmd.timer_id)) begin
						state_d = ST_REMOVE;
					end
				end
			end
			ST_REMOVE: state_d = (in_q.opcode == OP_START) ? ST_INSERT : ST_IDLE;
			ST_INSERT: state_d = ST_IDLE;
			ST_POP: begin
				if (!due) begin
					state_d = (cnt_q == '0) ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (rem_q == CNT_W'(1)) begin
					state_d = ST_RQ_RD;
				end
			end
			ST_RQ_RD: state_d = ST_RQ_INS;
			ST_RQ_INS: state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_RQ_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ccmd    = '{op: CELL_HOLD, key: in_q.timer_id,
			deadline: in_q.now_time + in_q.ticks, now: in_q.now_time};
		res_vld = 1'b0;
		res_d   = '{result_timer: in_q.timer_id, kind: KIND_ACK, is_pending: 1'b0,
			last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				res_d.result_timer = cmd.timer_id;
				if (start) begin
					if (cmd.opcode == OP_QUERY) begin
						res_vld          = 1'b1;
						res_d.is_pending = id_ok(cmd.timer_id)
							&& pending_q[to_idx(cmd.timer_id)];
					end else if (cmd.opcode != OP_MANAGE && !id_ok(cmd.timer_id)) begin
						res_vld = 1'b1;
					end
				end
			end
			ST_REMOVE: begin
				ccmd.op = CELL_REMOVE;
				res_vld = in_q.opcode == OP_STOP;
			end
			ST_INSERT: begin
				ccmd.op          = CELL_INSERT;
				res_vld          = 1'b1;
				res_d.is_pending = 1'b1;
			end
			ST_POP: begin
				if (due) begin
					ccmd.op = CELL_POP;
				end else if (cnt_q == '0) begin
					res_vld            = 1'b1;
					res_d.result_timer = '0;
					res_d.kind         = KIND_NONE;
				end
			end
			ST_EMIT: begin
				res_vld            = 1'b1;
				res_d.result_timer = lifo_q[0];
				res_d.kind         = KIND_EXPIRED;
				res_d.is_pending   = nz_q[lifo_idx];
				res_d.last         = rem_q == CNT_W'(1);
			end
			ST_RQ_RD: begin
				ccmd.op = CELL_HOLD;
			end
			ST_RQ_INS: begin
				ccmd.key      = fifo_q[0];
				ccmd.deadline = in_q.now_time + rd_q;
				if (nz_q[fifo_idx]) begin
					ccmd.op = CELL_INSERT;
				end
			end
			default: begin
				ccmd.op = CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			pending_q <= '0;
			nz_q      <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= res_vld;
			case (state_q)
				ST_IDLE: cnt_q <= '0;
				ST_REMOVE: begin
					if (in_q.opcode == OP_STOP) begin
						pending_q[in_idx] <= 1'b0;
					end else begin
						pending_q[in_idx] <= 1'b1;
						nz_q[in_idx]      <= in_q.periodic && (in_q.ticks != '0);
					end
				end
				ST_POP: begin
					if (due) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						rem_q <= cnt_q;
					end
				end
				ST_EMIT: rem_q <= rem_q - CNT_W'(1);
				ST_RQ_INS: begin
					cnt_q               <= cnt_q - CNT_W'(1);
					pending_q[fifo_idx] <= nz_q[fifo_idx];
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		if (state_q == ST_IDLE && start) begin
			in_q <= cmd;
		end
		if (state_q == ST_POP && due) begin
			lifo_q[0]                  <= head.tid;
			fifo_q[cnt_q[IDX_W-1:0]]   <= head.tid;
			for (int i = 1; i < NUM_TIMERS; i++) begin
				lifo_q[i] <= lifo_q[i-1];
			end
		end
		if (state_q == ST_EMIT) begin
			for (int i = 0; i < NUM_TIMERS - 1; i++) begin
				lifo_q[i] <= lifo_q[i+1];
			end
		end
		if (state_q == ST_RQ_INS) begin
			for (int i = 0; i < NUM_TIMERS - 1; i++) begin
				fifo_q[i] <= fifo_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REMOVE && in_q.opcode == OP_START) begin
			period_mem[in_idx] <= in_q.ticks;
		end
		if (state_q == ST_RQ_RD) begin
			rd_q <= period_mem[fifo_idx];
		end
	end

endmodule

// File: hw/rtl/sorted_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// sorted_timer_scheduler_top
// Deadline-sorted timer queue built from a row of queue cells.
// ----------------------------------------------------------------------------
// Channel  Ports                     Accepted when
// command  start, busy, cmd          start && !busy at the clock edge
// result   strobe, result            strobe high, one cycle per word
//
// Query, or start/stop of an out-of-range timer: answered from idle. Stop: a
// remove step. Start: remove, then insert. Manage with k due timers: k+1 head
// checks through the cell row, k result words, then a read and an insert state
// per expired timer for the period read; with none due, a none word. Reset
// empties the queue and stops all timers at once. Results cannot be stalled.
module sorted_timer_scheduler_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  stsched_pkg::in_word_t   cmd,
	output logic                   strobe,
	output stsched_pkg::out_word_t  result
);
	import stsched_pkg::*;

	cell_cmd_t  ccmd;
	cell_link_t links [NUM_TIMERS];
	logic       seen  [NUM_TIMERS];
	logic       go    [NUM_TIMERS];

	stsched_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.result (result),
		.ccmd   (ccmd),
		.head   (links[0])
	);

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		cell_link_t l_link, r_link;
		logic       l_seen, l_go;

		if (i == 0) begin : g_first
			assign l_link = '0;
			assign l_seen = 1'b0;
			assign l_go   = 1'b0;
		end else begin : g_mid
			assign l_link = links[i-1];
			assign l_seen = seen[i-1];
			assign l_go   = go[i-1];
		end

		if (i == NUM_TIMERS - 1) begin : g_last
			assign r_link = '0;
		end else begin : g_inner
			assign r_link = links[i+1];
		end

		stsched_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (ccmd),
			.left      (l_link),
			.left_seen (l_seen),
			.left_go   (l_go),
			.right     (r_link),
			.own       (links[i]),
			.seen      (seen[i]),
			.go        (go[i])
		);
	end

endmodule

// File: hw/rtl/stsched_checker.sv
// ----------------------------------------------------------------------------
// stsched_checker
// Port-level assertions for the sorted timer scheduler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stsched_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input stsched_pkg::in_word_t   cmd,
	input logic                   strobe,
	input stsched_pkg::out_word_t  result
);
	import stsched_pkg::*;

	`STS_ASSERT_NEXT(a_query_reply, start && !busy && cmd.opcode == OP_QUERY, strobe && result.last && !busy, "query word not answered next cycle")
	`STS_ASSERT_IMPL(a_none_word, strobe && result.kind == KIND_NONE, result.last && !result.is_pending, "none word malformed")
	`STS_ASSERT_NEXT(a_more_busy, strobe && !result.last, busy, "idle before final result word")
	`STS_ASSERT_NEXT(a_expired_run, strobe && result.kind == KIND_EXPIRED && !result.last, strobe && result.kind == KIND_EXPIRED, "gap in expired words")

endmodule

bind sorted_timer_scheduler_top stsched_checker u_chk (.*);
